// File: rtl/wdc_pkg.sv
package wdc_pkg;

	localparam int CHAN_W      = 8;
	localparam int COORD_W     = 10;
	localparam int CFG_DATA_W  = 11;
	localparam int CFG_INDEX_W = 1;
	localparam int TOTAL_W     = 25;
	// wide enough for three times the largest supported frame dimension
	localparam int DIM_W       = 14;

	localparam logic [CFG_DATA_W-1:0] CFG_DIM_RESET = 11'd64;

	// reciprocal of three, exact for every DIM_W-bit operand
	localparam int RECIP_W     = 16;
	localparam int RECIP_SHIFT = 17;
	localparam logic [RECIP_W-1:0] RECIP_THREE = 16'hAAAB;
	localparam int PROD_W      = DIM_W + RECIP_W;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		COLOR_RED   = 2'd0,
		COLOR_GREEN = 2'd1,
		COLOR_BLUE  = 2'd2,
		COLOR_NONE  = 2'd3
	} color_t;

	typedef struct packed {
		logic [DIM_W-1:0] col_lo;
		logic [DIM_W-1:0] col_hi;
		logic [DIM_W-1:0] row_lo;
		logic [DIM_W-1:0] row_hi;
	} window_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] red;
		logic [TOTAL_W-1:0] green;
		logic [TOTAL_W-1:0] blue;
	} totals_t;

	function automatic logic [DIM_W-1:0] div3(input logic [DIM_W-1:0] x);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(x) * PROD_W'(RECIP_THREE);
		return DIM_W'(prod >> RECIP_SHIFT);
	endfunction

	function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] acc,
			input logic [CHAN_W-1:0] v);
		logic [TOTAL_W:0] sum;
		sum = {1'b0, acc} + (TOTAL_W+1)'(v);
		return sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
	endfunction

endpackage

// File: rtl/wdc_pixel_if.sv
interface wdc_pixel_if;
	import wdc_pkg::*;

	logic               valid;
	logic               ready;
	logic [CHAN_W-1:0]  pixel_red;
	logic [CHAN_W-1:0]  pixel_green;
	logic [CHAN_W-1:0]  pixel_blue;
	logic [COORD_W-1:0] pixel_column;
	logic [COORD_W-1:0] pixel_row;
	logic               frame_end;

	modport source (
		output valid, pixel_red, pixel_green, pixel_blue, pixel_column, pixel_row, frame_end,
		input  ready
	);

	modport sink (
		input  valid, pixel_red, pixel_green, pixel_blue, pixel_column, pixel_row, frame_end,
		output ready
	);

endinterface

// File: rtl/wdc_result_if.sv
interface wdc_result_if;

	logic       valid;
	logic       ready;
	logic [1:0] blob_color;

	modport source (
		output valid, blob_color,
		input  ready
	);

	modport sink (
		input  valid, blob_color,
		output ready
	);

endinterface

// File: rtl/wdc_window.sv
module wdc_window #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_en,
	input  logic [wdc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [wdc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [wdc_pkg::COORD_W-1:0]       pixel_column,
	input  logic [wdc_pkg::COORD_W-1:0]       pixel_row,
	output logic                              in_window
);
	import wdc_pkg::*;

	localparam logic [DIM_W-1:0] WIDTH_LIMIT  = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] HEIGHT_LIMIT = DIM_W'(MAX_HEIGHT);

	logic [CFG_DATA_W-1:0] frame_width_q;
	logic [CFG_DATA_W-1:0] frame_height_q;
	window_t               bounds_q;
	logic [DIM_W-1:0]      col_ext;
	logic [DIM_W-1:0]      row_ext;

	function automatic window_t bounds_of(input logic [CFG_DATA_W-1:0] w_raw,
			input logic [CFG_DATA_W-1:0] h_raw);
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		window_t b;
		w = DIM_W'(w_raw);
		h = DIM_W'(h_raw);
		if (w > WIDTH_LIMIT) w = WIDTH_LIMIT;
		if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
		b.col_lo = div3(w);
		b.col_hi = div3(w << 1);
		b.row_lo = h >> 1;
		b.row_hi = ((h << 1) + h) >> 2;
		return b;
	endfunction

	// bounds are computed from the written value, so they apply on the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= CFG_DIM_RESET;
			frame_height_q <= CFG_DIM_RESET;
			bounds_q       <= bounds_of(CFG_DIM_RESET, CFG_DIM_RESET);
		end else if (cfg_write_en) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data;
					bounds_q      <= bounds_of(cfg_data, frame_height_q);
				end
				CFG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data;
					bounds_q       <= bounds_of(frame_width_q, cfg_data);
				end
			endcase
		end
	end

	assign col_ext = DIM_W'(pixel_column);
	assign row_ext = DIM_W'(pixel_row);

	assign in_window = (col_ext >= bounds_q.col_lo) && (col_ext < bounds_q.col_hi) &&
		(row_ext >= bounds_q.row_lo) && (row_ext < bounds_q.row_hi);

	a_col_order: assert property (@(posedge clk) disable iff (!arst_n)
		bounds_q.col_lo <= bounds_q.col_hi)
		else $error("column window inverted");

	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		bounds_q.row_lo <= bounds_q.row_hi)
		else $error("row window inverted");

	a_col_limit: assert property (@(posedge clk) disable iff (!arst_n)
		bounds_q.col_hi <= WIDTH_LIMIT && bounds_q.row_hi <= HEIGHT_LIMIT)
		else $error("window beyond clamped frame");

endmodule

// File: rtl/wdc_accum.sv
module wdc_accum (
	input  logic              clk,
	input  logic              arst_n,
	wdc_pixel_if.sink         pixels,
	input  logic              in_window,
	output wdc_pkg::totals_t  totals,
	output logic              snap_valid,
	input  logic              snap_ready
);
	import wdc_pkg::*;

	logic              valid_s1;
	logic              last_s1;
	logic [CHAN_W-1:0] red_s1;
	logic [CHAN_W-1:0] green_s1;
	logic [CHAN_W-1:0] blue_s1;

	totals_t           totals_q;
	totals_t           totals_next;
	logic              valid_s2;
	totals_t           totals_s2;

	logic              s2_free;
	logic              s1_go;
	logic              accept;

	assign s2_free = !valid_s2 || snap_ready;
	// a frame end needs room in the snapshot stage, other pixels always drain
	assign s1_go   = valid_s1 && (!last_s1 || s2_free);
	assign pixels.ready = !valid_s1 || s1_go;
	assign accept  = pixels.valid && pixels.ready;

	assign totals_next.red   = sat_add(totals_q.red, red_s1);
	assign totals_next.green = sat_add(totals_q.green, green_s1);
	assign totals_next.blue  = sat_add(totals_q.blue, blue_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			totals_q <= '0;
		end else begin
			if (pixels.ready) valid_s1 <= pixels.valid;
			if (s2_free) valid_s2 <= s1_go && last_s1;
			if (s1_go) begin
				totals_q <= last_s1 ? '0 : totals_next;
			end
		end
	end

	// pixels outside the window enter as zero
	always_ff @(posedge clk) begin
		if (accept) begin
			red_s1   <= in_window ? pixels.pixel_red   : '0;
			green_s1 <= in_window ? pixels.pixel_green : '0;
			blue_s1  <= in_window ? pixels.pixel_blue  : '0;
			last_s1  <= pixels.frame_end;
		end
		if (s1_go && last_s1 && s2_free) totals_s2 <= totals_next;
	end

	assign totals     = totals_s2;
	assign snap_valid = valid_s2;

	a_clear_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && last_s1 |=> totals_q == '0)
		else $error("sums not cleared after frame end");

	a_snap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !snap_ready |=> valid_s2 && $stable(totals_s2))
		else $error("snapshot lost while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pixels.ready |-> valid_s1 && last_s1 && valid_s2 && !snap_ready)
		else $error("input stalled without a blocked frame end");

endmodule

// File: rtl/wdc_classify.sv
module wdc_classify (
	input  logic              clk,
	input  logic              arst_n,
	input  wdc_pkg::totals_t  totals,
	input  logic              snap_valid,
	output logic              snap_ready,
	wdc_result_if.source      result
);
	import wdc_pkg::*;

	logic   valid_q;
	color_t blob_color_q;

	function automatic logic dominates(input logic [TOTAL_W-1:0] a,
			input logic [TOTAL_W-1:0] b, input logic [TOTAL_W-1:0] c);
		logic [TOTAL_W+1:0] b3;
		logic [TOTAL_W+1:0] c3;
		b3 = ((TOTAL_W+2)'(b) << 1) + (TOTAL_W+2)'(b);
		c3 = ((TOTAL_W+2)'(c) << 1) + (TOTAL_W+2)'(c);
		return ((TOTAL_W+2)'(a) > b3) && ((TOTAL_W+2)'(a) > c3);
	endfunction

	function automatic color_t classify(input totals_t t);
		if (dominates(t.red, t.green, t.blue)) return COLOR_RED;
		else if (dominates(t.green, t.red, t.blue)) return COLOR_GREEN;
		else if (dominates(t.blue, t.red, t.green)) return COLOR_BLUE;
		else return COLOR_NONE;
	endfunction

	assign snap_ready = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (snap_ready) begin
			valid_q <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_valid && snap_ready) blob_color_q <= classify(totals);
	end

	assign result.valid      = valid_q;
	assign result.blob_color = blob_color_q;

endmodule

// File: rtl/window_dominant_color_classifier.sv
// Dominant color classifier over a fixed window of the frame. Pixels arrive
// one transaction per cycle with their column and row; those inside columns
// [W/3, 2W/3) and rows [H/2, 3H/4) are added into saturating 25-bit red,
// green and blue sums, with W and H the frame registers clamped to
// MAX_WIDTH and MAX_HEIGHT. The pixel flagged frame_end is summed too, and
// then one result transaction follows: red, green or blue when that sum is
// more than three times both others (tested in that order), none otherwise,
// and the sums restart from zero. The block takes one pixel every cycle
// unless the input is stalled; a result passes from the input register
// through the snapshot register into the result register, and the input
// stalls only when a held-off result has two more frame ends queued behind
// it. A register write applies to pixels accepted from the next cycle on.
module window_dominant_color_classifier #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [wdc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [wdc_pkg::CFG_DATA_W-1:0]  cfg_data,
	wdc_pixel_if.sink                       pixels,
	wdc_result_if.source                    result
);
	import wdc_pkg::*;

	logic    in_window;
	totals_t totals;
	logic    snap_valid;
	logic    snap_ready;

	// frame registers and the window test on the incoming pixel
	wdc_window #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_column (pixels.pixel_column),
		.pixel_row    (pixels.pixel_row),
		.in_window    (in_window)
	);

	// input register, channel sums and the end-of-frame snapshot
	wdc_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixels     (pixels),
		.in_window  (in_window),
		.totals     (totals),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready)
	);

	// dominance compare into the result register
	wdc_classify u_classify (
		.clk        (clk),
		.arst_n     (arst_n),
		.totals     (totals),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.result     (result)
	);

endmodule

// File: bench/window_dominant_color_classifier_tb.sv
`timescale 1ns / 100ps

// pixel stream in, one dominant color per frame out
// a scoreboard keeps its own window bounds, saturating sums and color decision,
// fed by every accepted pixel transaction and drained by every result transaction
module window_dominant_color_classifier_tb;
	import wdc_pkg::*;

	localparam int MAX_W              = 1024;
	localparam int MAX_H              = 1024;
	localparam int CLK_HALF           = 4;
	localparam int RESET_CYCLES       = 8;
	// idle margin after the last result, before a register write
	localparam int SETTLE_CYCLES      = 6;
	localparam int CYCLE_LIMIT        = 1_000_000;
	localparam int IDLE_PERCENT       = 19;
	localparam int RANDOM_PIXELS      = 1450;
	localparam int PHASE_PIXELS       = 200;
	localparam int HOLD_OFF_CYCLES    = 300;
	localparam int MAX_REPORTS        = 40;
	localparam logic [CFG_DATA_W-1:0] FRAME_DIM_AT_RESET = 11'd64;
	localparam logic [TOTAL_W-1:0]    TOTAL_CEILING      = '1;

	typedef struct packed {
		logic [CHAN_W-1:0]  red;
		logic [CHAN_W-1:0]  green;
		logic [CHAN_W-1:0]  blue;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic               last;
	} pixel_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write_en;
	cfg_index_t            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	wdc_pixel_if  pixels ();
	wdc_result_if result ();

	window_dominant_color_classifier #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixels      (pixels),
		.result      (result)
	);

	// scoreboard copy of the registers and the three channel sums
	logic [CFG_DATA_W-1:0] width_reg;
	logic [CFG_DATA_W-1:0] height_reg;
	logic [TOTAL_W-1:0]    red_sum;
	logic [TOTAL_W-1:0]    green_sum;
	logic [TOTAL_W-1:0]    blue_sum;
	color_t                pending_colors[$];

	int pixels_sent;
	int frames_sent;
	int fail_count;
	int cycle_count;
	int hold_off_left;
	int color_seen[4];
	bit source_idle_on;
	bit sink_idle_on;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// window bounds from the registers, clamped to the block's maximum frame size
	function automatic void frame_window(output int col_lo, output int col_hi,
			output int row_lo, output int row_hi);
		int w;
		int h;
		w = (width_reg > MAX_W) ? MAX_W : int'(width_reg);
		h = (height_reg > MAX_H) ? MAX_H : int'(height_reg);
		col_lo = w / 3;
		col_hi = (2 * w) / 3;
		row_lo = h / 2;
		row_hi = (3 * h) / 4;
	endfunction

	function automatic logic [TOTAL_W-1:0] add_clamped(input logic [TOTAL_W-1:0] total,
			input logic [CHAN_W-1:0] value);
		logic [TOTAL_W:0] wide;
		wide = {1'b0, total} + (TOTAL_W+1)'(value);
		return (wide > {1'b0, TOTAL_CEILING}) ? TOTAL_CEILING : wide[TOTAL_W-1:0];
	endfunction

	// strictly more than three times both other sums
	function automatic bit beats(input longint a, input longint b, input longint c);
		return (a > 3 * b) && (a > 3 * c);
	endfunction

	function automatic color_t dominant_color();
		if (beats(longint'(red_sum), longint'(green_sum), longint'(blue_sum)))
			return COLOR_RED;
		if (beats(longint'(green_sum), longint'(red_sum), longint'(blue_sum)))
			return COLOR_GREEN;
		if (beats(longint'(blue_sum), longint'(red_sum), longint'(green_sum)))
			return COLOR_BLUE;
		return COLOR_NONE;
	endfunction

	// the frame end pixel is summed before the decision is taken
	function automatic void accumulate_pixel(input pixel_t p);
		int col_lo;
		int col_hi;
		int row_lo;
		int row_hi;
		frame_window(col_lo, col_hi, row_lo, row_hi);
		if (int'(p.column) >= col_lo && int'(p.column) < col_hi &&
				int'(p.row) >= row_lo && int'(p.row) < row_hi) begin
			red_sum   = add_clamped(red_sum, p.red);
			green_sum = add_clamped(green_sum, p.green);
			blue_sum  = add_clamped(blue_sum, p.blue);
		end
		if (p.last) begin
			pending_colors.push_back(dominant_color());
			red_sum     = '0;
			green_sum   = '0;
			blue_sum    = '0;
			frames_sent = frames_sent + 1;
		end
	endfunction

	function automatic pixel_t make_pixel(input int r, input int g, input int b,
			input int col, input int row, input bit last);
		pixel_t p;
		p.red    = CHAN_W'(r);
		p.green  = CHAN_W'(g);
		p.blue   = CHAN_W'(b);
		p.column = COORD_W'(col);
		p.row    = COORD_W'(row);
		p.last   = last;
		return p;
	endfunction

	// mostly inside the window with one channel leaning high; some pixels are pure noise
	function automatic pixel_t random_pixel(input color_t tint, input bit last);
		pixel_t p;
		int     col_lo;
		int     col_hi;
		int     row_lo;
		int     row_hi;
		frame_window(col_lo, col_hi, row_lo, row_hi);
		if (col_lo < col_hi && row_lo < row_hi && $urandom_range(99) < 80) begin
			p.column = COORD_W'($urandom_range(col_hi - 1, col_lo));
			p.row    = COORD_W'($urandom_range(row_hi - 1, row_lo));
		end else begin
			p.column = COORD_W'($urandom_range((1 << COORD_W) - 1));
			p.row    = COORD_W'($urandom_range((1 << COORD_W) - 1));
		end
		if (tint == COLOR_NONE || $urandom_range(19) == 0) begin
			p.red   = CHAN_W'($urandom_range(255));
			p.green = CHAN_W'($urandom_range(255));
			p.blue  = CHAN_W'($urandom_range(255));
		end else begin
			p.red   = CHAN_W'($urandom_range(80));
			p.green = CHAN_W'($urandom_range(80));
			p.blue  = CHAN_W'($urandom_range(80));
			case (tint)
				COLOR_RED:   p.red   = CHAN_W'($urandom_range(255, 100));
				COLOR_GREEN: p.green = CHAN_W'($urandom_range(255, 100));
				default:     p.blue  = CHAN_W'($urandom_range(255, 100));
			endcase
		end
		p.last = last;
		return p;
	endfunction

	// zero, tiny, exact maximum, above maximum, or a plain size
	function automatic logic [CFG_DATA_W-1:0] pick_dimension();
		case ($urandom_range(9))
			0:       return '0;
			1:       return CFG_DATA_W'($urandom_range(3, 1));
			2:       return CFG_DATA_W'(MAX_W);
			3:       return '1;
			4:       return CFG_DATA_W'($urandom_range(2046, MAX_W + 1));
			default: return CFG_DATA_W'($urandom_range(MAX_W - 1, 4));
		endcase
	endfunction

	// offer one pixel transaction and hold it until the block takes it
	task automatic send_pixel(input pixel_t p);
		while (source_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
			pixels.valid <= 1'b0;
			@(posedge clk);
		end
		pixels.valid        <= 1'b1;
		pixels.pixel_red    <= p.red;
		pixels.pixel_green  <= p.green;
		pixels.pixel_blue   <= p.blue;
		pixels.pixel_column <= p.column;
		pixels.pixel_row    <= p.row;
		pixels.frame_end    <= p.last;
		@(posedge clk);
		while (!pixels.ready)
			@(posedge clk);
		accumulate_pixel(p);
		pixels_sent = pixels_sent + 1;
	endtask

	task automatic send_random_frame(input int length);
		color_t tint;
		tint = color_t'($urandom_range(3));
		for (int i = 0; i < length; i++)
			send_pixel(random_pixel(tint, i == length - 1));
	endtask

	// all results in, then a settle margin for pixels that give no result
	task automatic wait_until_idle();
		pixels.valid <= 1'b0;
		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_frame_reg(input cfg_index_t index, input logic [CFG_DATA_W-1:0] value);
		wait_until_idle();
		cfg_write_en <= 1'b1;
		cfg_index    <= index;
		cfg_data     <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		case (index)
			CFG_FRAME_WIDTH:  width_reg  = value;
			CFG_FRAME_HEIGHT: height_reg = value;
		endcase
		// new bounds apply from the next cycle, keep a little margin
		repeat (2) @(posedge clk);
	endtask

	task automatic set_frame_size(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
		write_frame_reg(CFG_FRAME_WIDTH, w);
		write_frame_reg(CFG_FRAME_HEIGHT, h);
	endtask

	// reset size 64x64: columns [21,42), rows [32,48)
	task automatic test_window_edges();
		send_pixel(make_pixel(255, 0, 0, 21, 32, 1));
		send_pixel(make_pixel(0, 255, 0, 41, 47, 1));
		// just outside each edge, red must not be summed
		send_pixel(make_pixel(255, 0, 0, 20, 40, 0));
		send_pixel(make_pixel(255, 0, 0, 21, 31, 0));
		send_pixel(make_pixel(255, 0, 0, 42, 40, 0));
		send_pixel(make_pixel(255, 0, 0, 30, 48, 0));
		send_pixel(make_pixel(0, 0, 1, 30, 40, 1));
		// exactly three times is a tie, one more wins
		send_pixel(make_pixel(3, 1, 0, 30, 40, 1));
		send_pixel(make_pixel(4, 1, 1, 30, 40, 1));
		// frame end outside the window with nothing summed
		send_pixel(make_pixel(255, 255, 255, (1 << COORD_W) - 1, (1 << COORD_W) - 1, 1));
		send_pixel(make_pixel(0, 0, 0, 0, 0, 1));
		// repeated pixel counts twice: 22 green beats 3 x 7 red only then
		send_pixel(make_pixel(7, 0, 0, 26, 36, 0));
		send_pixel(make_pixel(0, 11, 0, 25, 35, 0));
		send_pixel(make_pixel(0, 11, 0, 25, 35, 1));
		send_pixel(make_pixel(255, 255, 255, 30, 40, 1));
	endtask

	task automatic test_frame_size_extremes();
		// zero width leaves an empty window
		set_frame_size(0, 64);
		send_pixel(make_pixel(255, 0, 0, 0, 40, 1));
		// smallest window: column 1, row 2
		set_frame_size(3, 4);
		send_pixel(make_pixel(0, 0, 200, 1, 2, 1));
		send_pixel(make_pixel(200, 0, 0, 2, 2, 0));
		send_pixel(make_pixel(200, 0, 0, 1, 3, 0));
		send_pixel(make_pixel(200, 0, 0, 0, 2, 0));
		send_pixel(make_pixel(0, 0, 1, 1, 2, 1));
		// full size: columns [341,682), rows [512,768)
		set_frame_size(CFG_DATA_W'(MAX_W), CFG_DATA_W'(MAX_H));
		send_pixel(make_pixel(9, 0, 0, 341, 512, 0));
		send_pixel(make_pixel(0, 1, 0, 681, 767, 1));
		send_pixel(make_pixel(0, 255, 0, 340, 600, 0));
		send_pixel(make_pixel(0, 255, 0, 682, 600, 0));
		send_pixel(make_pixel(0, 255, 0, 500, 511, 0));
		send_pixel(make_pixel(0, 255, 0, 500, 768, 0));
		send_pixel(make_pixel(0, 0, 1, 500, 600, 1));
		// register above the maximum is clamped, so the same bounds apply
		set_frame_size('1, '1);
		send_pixel(make_pixel(255, 0, 0, 682, 600, 0));
		send_pixel(make_pixel(255, 0, 0, 500, 768, 0));
		send_pixel(make_pixel(0, 1, 0, 500, 600, 1));
		set_frame_size(1, 0);
		send_pixel(make_pixel(255, 0, 0, 0, 0, 1));
	endtask

	// receiver stops for a long stretch while short frames keep coming,
	// so a result backs up and the pixel input stalls behind it
	task automatic test_output_backpressure();
		source_idle_on = 1'b0;
		hold_off_left  = HOLD_OFF_CYCLES;
		repeat (40) send_random_frame($urandom_range(2, 1));
		source_idle_on = 1'b1;
	endtask

	task automatic test_random_frames();
		int start_count;
		int phase_start;
		start_count = pixels_sent;
		while (pixels_sent - start_count < RANDOM_PIXELS) begin
			set_frame_size(pick_dimension(), pick_dimension());
			// first phase runs with no idling on either side
			source_idle_on = (pixels_sent != start_count) && ($urandom_range(3) != 0);
			sink_idle_on   = (pixels_sent != start_count) && ($urandom_range(3) != 0);
			phase_start    = pixels_sent;
			while (pixels_sent - phase_start < PHASE_PIXELS) begin
				if ($urandom_range(9) == 0)
					send_random_frame($urandom_range(40, 9));
				else
					send_random_frame($urandom_range(6, 1));
			end
		end
		source_idle_on = 1'b1;
		sink_idle_on   = 1'b1;
	endtask

	// result side: check each result transaction, then pick the next ready
	initial begin
		color_t want;
		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result.valid && result.ready) begin
				if (pending_colors.size() == 0) begin
					fail_count = fail_count + 1;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: unexpected result transaction, expected none, actual %0d",
							$time, result.blob_color);
				end else begin
					want = pending_colors.pop_front();
					color_seen[want] = color_seen[want] + 1;
					if (result.blob_color !== want) begin
						fail_count = fail_count + 1;
						if (fail_count <= MAX_REPORTS)
							$display("%0t: blob_color mismatch, expected %0d (%s), actual %0d",
								$time, want, want.name(), result.blob_color);
					end
				end
			end
			if (hold_off_left > 0) begin
				hold_off_left = hold_off_left - 1;
				result.ready <= 1'b0;
			end else begin
				result.ready <= !(sink_idle_on && $urandom_range(99) < IDLE_PERCENT);
			end
		end
	end

	// overall cycle limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count = cycle_count + 1;
		end
		$display("%0t: no end after %0d cycles", $time, CYCLE_LIMIT);
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n              <= 1'b0;
		cfg_write_en        <= 1'b0;
		cfg_index           <= CFG_FRAME_WIDTH;
		cfg_data            <= '0;
		pixels.valid        <= 1'b0;
		pixels.pixel_red    <= '0;
		pixels.pixel_green  <= '0;
		pixels.pixel_blue   <= '0;
		pixels.pixel_column <= '0;
		pixels.pixel_row    <= '0;
		pixels.frame_end    <= 1'b0;
		width_reg      = FRAME_DIM_AT_RESET;
		height_reg     = FRAME_DIM_AT_RESET;
		red_sum        = '0;
		green_sum      = '0;
		blue_sum       = '0;
		pixels_sent    = 0;
		frames_sent    = 0;
		fail_count     = 0;
		hold_off_left  = 0;
		source_idle_on = 1'b1;
		sink_idle_on   = 1'b1;
		foreach (color_seen[i])
			color_seen[i] = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_window_edges();
		test_frame_size_extremes();
		test_output_backpressure();
		test_random_frames();

		wait_until_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d pixel transactions in %0d frames: window edges, size extremes,",
			pixels_sent, frames_sent);
		$display("output stall and random sizes; red %0d green %0d blue %0d none %0d",
			color_seen[COLOR_RED], color_seen[COLOR_GREEN], color_seen[COLOR_BLUE],
			color_seen[COLOR_NONE]);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/wdc_pkg.sv
rtl/wdc_pixel_if.sv
rtl/wdc_result_if.sv
rtl/wdc_window.sv
rtl/wdc_accum.sv
rtl/wdc_classify.sv
rtl/window_dominant_color_classifier.sv
bench/window_dominant_color_classifier_tb.sv
